// ===== rtl/adu_pkg.sv =====
// Package for the activation derivative unit: mode and register codes,
// fixed-point widths, exp/divider constants and the pipeline tag type.
// No dependencies; used by adu_exp, adu_div and the top level.
package adu_pkg;

  // Activation modes held in the mode register
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_RELU    = 3'd0;
  localparam mode_t MODE_SIGMOID = 3'd1;
  localparam mode_t MODE_TANH    = 3'd2;
  localparam mode_t MODE_LEAKY   = 3'd3;
  localparam mode_t MODE_SWISH   = 3'd4;
  localparam mode_t MODE_LINEAR  = 3'd5;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SLOPE = 1'b1;
  localparam int SLOPE_W = 15;
  localparam logic [SLOPE_W-1:0] SLOPE_RESET = 15'd164;

  // Clamped input (Q6.12 signed, +/-16.0) and exp argument (up to 32.0)
  localparam int ZC_W    = 18;
  localparam int X_W     = 18;
  localparam int Z_CLAMP = 65536;

  // Internal Q0.24 fixed point for exp, sigmoid and friends
  localparam int FRAC  = 24;
  localparam int Q_ONE = 16777216;
  localparam int E_W   = 25;
  localparam int Q_W   = 24;
  localparam int P_W   = 47;

  // x * log2(e): x in Q.12, constant in Q1.30, product in Q.42
  localparam int LOG2E_W = 31;
  localparam logic [LOG2E_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam int Y_W    = X_W + LOG2E_W;
  localparam int Y_FRAC = 42;
  localparam int K_W    = 6;
  localparam int SEL_W  = 2;
  localparam int G_W    = 22;

  // 2^-g for g in [0, 0.25) by a degree 5 polynomial, Horner form
  localparam int HORNER_N = 5;
  localparam logic [E_W-1:0] HORNER_C5 = 25'd22370;

  // Divider: two quotient bits per stage
  localparam int REM_W      = 25;
  localparam int DEN_W      = 26;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = Q_W / DIV_BITS;

  // Derivative before output saturation, signed Q.14
  localparam int D_W     = 18;
  localparam int OUT_ONE = 16384;

  // Valid bit and clamped input travelling beside the data
  typedef struct packed {
    logic                   vld;
    logic signed [ZC_W-1:0] zc;
  } tag_t;

  // Horner coefficients, innermost first: ln2^n/n! in Q0.24, then 1.0
  function automatic logic [E_W-1:0] horner_coef(input int j);
    logic [E_W-1:0] c;
    case (j)
      0:       c = 25'd161365;
      1:       c = 25'd931204;
      2:       c = 25'd4030332;
      3:       c = 25'd11629080;
      default: c = 25'd16777216;
    endcase
    return c;
  endfunction

  // 2^(-sel/4) in Q0.24
  function automatic logic [E_W-1:0] pow2_quarter(input logic [SEL_W-1:0] sel);
    logic [E_W-1:0] c;
    case (sel)
      2'd0:    c = 25'd16777216;
      2'd1:    c = 25'd14107901;
      2'd2:    c = 25'd11863283;
      default: c = 25'd9975792;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/adu_exp.sv =====
// Pipelined exp(-x) for x >= 0 in Q.12, result in Q0.24.
// Eight register stages; depends on adu_pkg.
module adu_exp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  adu_pkg::tag_t            tag_i,
  input  logic [adu_pkg::X_W-1:0]  x_i,
  output adu_pkg::tag_t            tag_o,
  output logic [adu_pkg::E_W-1:0]  e_o
);

  localparam int NH = adu_pkg::HORNER_N;
  localparam int HP_W = adu_pkg::E_W + adu_pkg::G_W;
  localparam int MP_W = 2 * adu_pkg::E_W;

  // Split stage: y = x * log2(e) = k + sel/4 + g
  logic [adu_pkg::Y_W-1:0] y;
  assign y = {{adu_pkg::LOG2E_W{1'b0}}, x_i} * {{adu_pkg::X_W{1'b0}}, adu_pkg::LOG2E_Q30};

  logic                          vld_r [0:NH];
  logic signed [adu_pkg::ZC_W-1:0] zc_r [0:NH];
  logic [adu_pkg::G_W-1:0]       g_r   [0:NH];
  logic [adu_pkg::K_W-1:0]       k_r   [0:NH];
  logic [adu_pkg::SEL_W-1:0]     sel_r [0:NH];
  logic [adu_pkg::E_W-1:0]       h_r   [1:NH];
  logic [adu_pkg::E_W-1:0]       h_nxt [1:NH];

  // One Horner step per stage
  always_comb begin
    logic [HP_W-1:0]         hp;
    logic [adu_pkg::E_W-1:0] hin;
    for (int j = 1; j <= NH; j++) begin
      hin = (j == 1) ? adu_pkg::HORNER_C5 : h_r[(j > 1) ? j - 1 : 1];
      hp = HP_W'(hin) * HP_W'(g_r[j-1]);
      h_nxt[j] = adu_pkg::horner_coef(j - 1) - adu_pkg::E_W'(hp >> adu_pkg::FRAC);
    end
  end

  // Scale by 2^(-sel/4), then shift right by k
  logic [MP_W-1:0]           mp;
  logic [adu_pkg::E_W-1:0]   m_r;
  logic [adu_pkg::K_W-1:0]   km_r;
  logic                      vld_m_r;
  logic signed [adu_pkg::ZC_W-1:0] zc_m_r;
  logic [adu_pkg::E_W-1:0]   e_r;
  logic                      vld_e_r;
  logic signed [adu_pkg::ZC_W-1:0] zc_e_r;

  assign mp = MP_W'(adu_pkg::pow2_quarter(sel_r[NH])) * MP_W'(h_r[NH]);

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= NH; j++) vld_r[j] <= 1'b0;
      vld_m_r <= 1'b0;
      vld_e_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= tag_i.vld;
      for (int j = 1; j <= NH; j++) vld_r[j] <= vld_r[j-1];
      vld_m_r <= vld_r[NH];
      vld_e_r <= vld_m_r;
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (en) begin
      zc_r[0]  <= tag_i.zc;
      k_r[0]   <= y[adu_pkg::Y_FRAC +: adu_pkg::K_W];
      sel_r[0] <= y[adu_pkg::Y_FRAC-1 -: adu_pkg::SEL_W];
      g_r[0]   <= y[adu_pkg::Y_FRAC-1-adu_pkg::SEL_W -: adu_pkg::G_W];
      for (int j = 1; j <= NH; j++) begin
        zc_r[j]  <= zc_r[j-1];
        k_r[j]   <= k_r[j-1];
        sel_r[j] <= sel_r[j-1];
        g_r[j]   <= g_r[j-1];
        h_r[j]   <= h_nxt[j];
      end
      m_r    <= adu_pkg::E_W'(mp >> adu_pkg::FRAC);
      km_r   <= k_r[NH];
      zc_m_r <= zc_r[NH];
      e_r    <= m_r >> km_r;
      zc_e_r <= zc_m_r;
    end
  end

  assign tag_o = '{vld: vld_e_r, zc: zc_e_r};
  assign e_o   = e_r;

endmodule

// ===== rtl/adu_div.sv =====
// Pipelined restoring divider: q = floor(e * 2^24 / (2^24 + e)), Q0.24.
// DIV_STAGES register stages of DIV_BITS quotient bits; depends on adu_pkg.
module adu_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  adu_pkg::tag_t            tag_i,
  input  logic [adu_pkg::E_W-1:0]  e_i,
  output adu_pkg::tag_t            tag_o,
  output logic [adu_pkg::Q_W-1:0]  q_o
);

  localparam int NS = adu_pkg::DIV_STAGES;

  logic                            vld_r   [NS];
  logic signed [adu_pkg::ZC_W-1:0] zc_r    [NS];
  logic [adu_pkg::REM_W-1:0]       rem_r   [NS];
  logic [adu_pkg::DEN_W-1:0]       den_r   [NS];
  logic [adu_pkg::Q_W-1:0]         quo_r   [NS];
  logic [adu_pkg::REM_W-1:0]       rem_nxt [NS];
  logic [adu_pkg::DEN_W-1:0]       den_nxt [NS];
  logic [adu_pkg::Q_W-1:0]         quo_nxt [NS];

  // Shift, compare and subtract; remainder always stays below the divisor
  always_comb begin
    logic [adu_pkg::REM_W-1:0] r;
    logic [adu_pkg::DEN_W-1:0] r2;
    logic [adu_pkg::DEN_W-1:0] d;
    logic [adu_pkg::Q_W-1:0]   qv;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        r  = adu_pkg::REM_W'(e_i);
        d  = adu_pkg::DEN_W'(adu_pkg::Q_ONE) + adu_pkg::DEN_W'(e_i);
        qv = '0;
      end else begin
        r  = rem_r[(j > 0) ? j - 1 : 0];
        d  = den_r[(j > 0) ? j - 1 : 0];
        qv = quo_r[(j > 0) ? j - 1 : 0];
      end
      for (int b = 0; b < adu_pkg::DIV_BITS; b++) begin
        r2 = {r, 1'b0};
        if (r2 >= d) begin
          r  = adu_pkg::REM_W'(r2 - d);
          qv = {qv[adu_pkg::Q_W-2:0], 1'b1};
        end else begin
          r  = adu_pkg::REM_W'(r2);
          qv = {qv[adu_pkg::Q_W-2:0], 1'b0};
        end
      end
      rem_nxt[j] = r;
      den_nxt[j] = d;
      quo_nxt[j] = qv;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NS; j++) vld_r[j] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= tag_i.vld;
      for (int j = 1; j < NS; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  // Data path
  always_ff @(posedge clk) begin
    if (en) begin
      zc_r[0] <= tag_i.zc;
      for (int j = 1; j < NS; j++) zc_r[j] <= zc_r[j-1];
      for (int j = 0; j < NS; j++) begin
        rem_r[j] <= rem_nxt[j];
        den_r[j] <= den_nxt[j];
        quo_r[j] <= quo_nxt[j];
      end
    end
  end

  assign tag_o = '{vld: vld_r[NS-1], zc: zc_r[NS-1]};
  assign q_o   = quo_r[NS-1];

endmodule

// ===== rtl/activation_derivative_unit.sv =====
// Top level of the activation derivative unit: configuration registers,
// input clamp, derivative assembly and output register.
// Depends on adu_pkg, adu_exp and adu_div.
//
// Usage:
//   Input channel in_valid/in_ready carries one signed Q4.12 pre-activation
//   value per transaction; output channel out_valid/out_ready returns the
//   derivative of the selected activation at that value in signed Q2.14,
//   saturated to DATA_WIDTH bits. One result per input, in order.
//   cfg_we/cfg_addr/cfg_wdata write the mode (index 0) and leaky slope
//   (index 1); write them only while the unit is empty. The pipe has
//   one clamp stage, eight exp stages (split, five polynomial steps,
//   scale, shift), twelve divider stages at two quotient bits each,
//   and four stages for the product, rounding and saturation. Every
//   mode takes the same path, so order is preserved.
//   Throughput is one transaction per cycle; the whole pipe advances as
//   one whenever the output register is empty or being taken.
//   When the receiver stalls, all stages hold and in_ready drops; nothing
//   is lost or repeated. Reset clears every valid bit and restores mode
//   relu and slope 164; no clearing pass is needed.
module activation_derivative_unit #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [DATA_WIDTH-1:0]         in_pre_activation,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [DATA_WIDTH-1:0]         out_derivative,
  input  logic                                 cfg_we,
  input  logic [adu_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [adu_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int ZE_W  = (DATA_WIDTH > adu_pkg::ZC_W) ? DATA_WIDTH : adu_pkg::ZC_W;
  localparam int SAT_W = (DATA_WIDTH > adu_pkg::D_W) ? DATA_WIDTH : adu_pkg::D_W;
  localparam int PF_W  = adu_pkg::E_W + adu_pkg::Q_W;
  localparam int SQ_W  = adu_pkg::P_W - adu_pkg::FRAC;
  localparam int PR_W  = adu_pkg::ZC_W + SQ_W + 1;
  localparam int ACC_W = PR_W + 1;
  localparam logic signed [ZE_W-1:0]  Z_HI    = ZE_W'(adu_pkg::Z_CLAMP);
  localparam logic signed [ZE_W-1:0]  Z_LO    = -Z_HI;
  localparam logic signed [SAT_W-1:0] OUT_HI  =
    SAT_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] OUT_LO  = -OUT_HI - SAT_W'(1);
  localparam logic signed [adu_pkg::D_W-1:0] D_ONE = adu_pkg::D_W'(adu_pkg::OUT_ONE);

  logic en;
  logic out_valid_r;

  // Whole pipe advances when the output register is free or being taken
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Configuration registers
  adu_pkg::mode_t                 mode_r;
  logic [adu_pkg::SLOPE_W-1:0]    slope_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= adu_pkg::MODE_RELU;
      slope_r <= adu_pkg::SLOPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        adu_pkg::CFG_MODE:  mode_r  <= cfg_wdata[2:0];
        adu_pkg::CFG_SLOPE: slope_r <= cfg_wdata[adu_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: clamp to +/-16.0, magnitude, doubled for tanh
  logic signed [ZE_W-1:0]          z_ext;
  logic signed [ZE_W-1:0]          z_cl;
  logic signed [adu_pkg::ZC_W-1:0] zc;
  logic [adu_pkg::X_W-1:0]         mag;
  logic [adu_pkg::X_W-1:0]         x_nxt;
  logic                            vld1_r;
  logic signed [adu_pkg::ZC_W-1:0] zc1_r;
  logic [adu_pkg::X_W-1:0]         x1_r;

  always_comb begin
    z_ext = ZE_W'(in_pre_activation);
    if (z_ext > Z_HI)      z_cl = Z_HI;
    else if (z_ext < Z_LO) z_cl = Z_LO;
    else                   z_cl = z_ext;
    zc  = z_cl[adu_pkg::ZC_W-1:0];
    mag = zc[adu_pkg::ZC_W-1] ? adu_pkg::X_W'(-zc) : adu_pkg::X_W'(zc);
    x_nxt = (mode_r == adu_pkg::MODE_TANH) ? {mag[adu_pkg::X_W-2:0], 1'b0} : mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zc1_r <= zc;
      x1_r  <= x_nxt;
    end
  end

  // exp(-x) and q = e / (1 + e), i.e. sigmoid(-|z|), or sigmoid(-2|z|) for tanh
  adu_pkg::tag_t             tag_s1;
  adu_pkg::tag_t             tag_e;
  adu_pkg::tag_t             tag_q;
  logic [adu_pkg::E_W-1:0]   e_e;
  logic [adu_pkg::Q_W-1:0]   q_q;

  assign tag_s1 = '{vld: vld1_r, zc: zc1_r};

  adu_exp u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_s1),
    .x_i   (x1_r),
    .tag_o (tag_e),
    .e_o   (e_e)
  );

  adu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tag_i (tag_e),
    .e_i   (e_e),
    .tag_o (tag_q),
    .q_o   (q_q)
  );

  // Stage 22: s = 1 - q, p = s * q, sigmoid(z) picked by sign
  logic [adu_pkg::E_W-1:0]         s_q;
  logic [PF_W-1:0]                 pfull;
  logic                            vld_p_r;
  logic signed [adu_pkg::ZC_W-1:0] zc_p_r;
  logic [adu_pkg::P_W-1:0]         p_r;
  logic [adu_pkg::E_W-1:0]         sz_p_r;

  assign s_q   = adu_pkg::E_W'(adu_pkg::Q_ONE) - adu_pkg::E_W'(q_q);
  assign pfull = PF_W'(s_q) * PF_W'(q_q);

  // Stage 23: swish product z * s*q and the other modes' results
  logic [SQ_W-1:0]                 sq;
  logic signed [PR_W-1:0]          prod_nxt;
  logic [adu_pkg::P_W-1:0]         p_sig;
  logic [adu_pkg::P_W-1:0]         p_tanh;
  logic signed [adu_pkg::D_W-1:0]  doth_nxt;
  logic                            vld_m_r;
  logic signed [PR_W-1:0]          prod_r;
  logic [adu_pkg::E_W-1:0]         sz_m_r;
  logic signed [adu_pkg::D_W-1:0]  doth_r;

  assign sq       = p_r[adu_pkg::P_W-1:adu_pkg::FRAC];
  assign prod_nxt = PR_W'(zc_p_r) * PR_W'($signed({1'b0, sq}));
  assign p_sig    = p_r + (adu_pkg::P_W'(1) << 33);
  assign p_tanh   = p_r + (adu_pkg::P_W'(1) << 31);

  always_comb begin
    unique case (mode_r)
      adu_pkg::MODE_RELU:    doth_nxt = (zc_p_r > 0) ? D_ONE : '0;
      adu_pkg::MODE_SIGMOID: doth_nxt = adu_pkg::D_W'(p_sig >> 34);
      adu_pkg::MODE_TANH:    doth_nxt = adu_pkg::D_W'(p_tanh >> 32);
      adu_pkg::MODE_LEAKY:   doth_nxt = (zc_p_r > 0) ? D_ONE : adu_pkg::D_W'(slope_r);
      adu_pkg::MODE_LINEAR:  doth_nxt = D_ONE;
      default:               doth_nxt = '0;
    endcase
  end

  // Stage 24: swish = sigmoid(z) + z*s*q, rounded half up to Q.14
  logic signed [ACC_W-1:0]         acc;
  logic signed [adu_pkg::D_W-1:0]  d_nxt;
  logic                            vld_d_r;
  logic signed [adu_pkg::D_W-1:0]  d_r;

  always_comb begin
    acc = $signed(ACC_W'({sz_m_r, 12'b0})) + ACC_W'(prod_r) + (ACC_W'(1) << 21);
    if (mode_r == adu_pkg::MODE_SWISH) d_nxt = adu_pkg::D_W'(acc >>> 22);
    else                               d_nxt = doth_r;
  end

  // Stage 25: saturate into the output register
  logic signed [SAT_W-1:0]         d_ext;
  logic signed [SAT_W-1:0]         d_sat;
  logic signed [DATA_WIDTH-1:0]    out_derivative_r;

  always_comb begin
    d_ext = SAT_W'(d_r);
    if (d_ext > OUT_HI)      d_sat = OUT_HI;
    else if (d_ext < OUT_LO) d_sat = OUT_LO;
    else                     d_sat = d_ext;
  end

  // Valid bits of the tail stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r     <= 1'b0;
      vld_m_r     <= 1'b0;
      vld_d_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_p_r     <= tag_q.vld;
      vld_m_r     <= vld_p_r;
      vld_d_r     <= vld_m_r;
      out_valid_r <= vld_d_r;
    end
  end

  // Tail data path
  always_ff @(posedge clk) begin
    if (en) begin
      zc_p_r           <= tag_q.zc;
      p_r              <= pfull[adu_pkg::P_W-1:0];
      sz_p_r           <= tag_q.zc[adu_pkg::ZC_W-1] ? adu_pkg::E_W'(q_q) : s_q;
      prod_r           <= prod_nxt;
      sz_m_r           <= sz_p_r;
      doth_r           <= doth_nxt;
      d_r              <= d_nxt;
      out_derivative_r <= d_sat[DATA_WIDTH-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_derivative = out_derivative_r;

endmodule

// ===== rtl/adu_checker.sv =====
// Port-level assertions for the activation derivative unit, bound to the
// top level. Depends only on the top level's port names and DATA_WIDTH.
module adu_port_checker #(
  parameter int DATA_WIDTH = 16
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [DATA_WIDTH-1:0] out_derivative
);

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before its transaction");

  // A held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_derivative))
    else $error("out_derivative changed while stalled");

  // Empty output stage never blocks the input
  a_ready_when_empty: assert property (@(posedge clk)
    !out_valid |-> in_ready)
    else $error("in_ready low with output register empty");

  // A result being taken frees the pipe for a new input
  a_ready_on_take: assert property (@(posedge clk)
    out_valid && out_ready |-> in_ready)
    else $error("in_ready low while a result is taken");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind activation_derivative_unit adu_port_checker #(.DATA_WIDTH(DATA_WIDTH)) u_adu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_derivative (out_derivative)
);
